// ===== sv/sspc_pkg.sv =====
// Shared types, constants and helpers for the Stanley steer / PI speed control block.
package sspc_pkg;

	localparam int FracBits = 16;
	localparam int AngBits = 24;
	localparam int CfgW = 23;
	localparam int CordicSteps = 24;
	localparam logic [23:0] DtQ24 = 24'd167772;
	localparam logic [24:0] SteerScaleQ24 = 25'd19617626;
	localparam logic signed [27:0] HalfPiQ24 = 28'sd26353589;

	localparam logic [2:0] RegTargetSpeed = 3'd0;
	localparam logic [2:0] RegPropGain = 3'd1;
	localparam logic [2:0] RegIntGain = 3'd2;
	localparam logic [2:0] RegIntegralLimit = 3'd3;
	localparam logic [2:0] RegStanleyGain = 3'd4;
	localparam logic [2:0] RegWheelbase = 3'd5;
	localparam logic [2:0] RegYawGain = 3'd6;
	localparam logic [2:0] RegCurvGain = 3'd7;

	localparam logic OpSpeed = 1'b0;
	localparam logic OpPath = 1'b1;

	typedef struct packed {
		logic operation;
		logic signed [31:0] speed;
		logic signed [31:0] cross_track_error;
		logic signed [31:0] heading_error;
		logic signed [31:0] path_curvature;
	} in_item_t;

	typedef struct packed {
		logic [16:0] throttle;
		logic [16:0] brake;
		logic signed [17:0] steer;
	} out_item_t;

	typedef struct packed {
		logic [2:0] index;
		logic [31:0] data;
	} cfg_item_t;

	// serial multiplier request/response
	typedef struct packed {
		logic start;
		logic signed [63:0] a;
		logic [31:0] b;
	} mul_req_t;

	typedef struct packed {
		logic done;
		logic signed [95:0] p;
	} mul_rsp_t;

	typedef struct packed {
		logic start;
		logic signed [63:0] y;
		logic signed [63:0] x;
	} atan_req_t;

	typedef struct packed {
		logic done;
		logic signed [27:0] z;
	} atan_rsp_t;

	function automatic logic signed [27:0] atan_entry(input logic [4:0] i);
		logic signed [27:0] r;
		begin
			unique case (i)
				5'd0: r = 28'sd13176795;
				5'd1: r = 28'sd7778716;
				5'd2: r = 28'sd4110060;
				5'd3: r = 28'sd2086331;
				5'd4: r = 28'sd1047214;
				5'd5: r = 28'sd524117;
				5'd6: r = 28'sd262123;
				5'd7: r = 28'sd131069;
				default: r = 28'sd1 <<< (5'd24 - i);
			endcase
			return r;
		end
	endfunction

endpackage

// ===== sv/sspc_mul.sv =====
// Bit-serial signed-by-unsigned multiplier, one multiplier bit per cycle.
module sspc_mul import sspc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);
	logic signed [95:0] acc_q;
	logic signed [95:0] mcand_q;
	logic [31:0] mplier_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			mcand_q <= 96'(req.a);
			mplier_q <= req.b;
		end else if (busy_q) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.p = acc_q;

	no_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !done_q) else $error("multiplier done while busy");
	done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("multiplier done without run");
endmodule

// ===== sv/sspc_atan.sv =====
// Vectoring CORDIC arctangent with normalization, one step per cycle.
module sspc_atan import sspc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  atan_req_t req,
	output atan_rsp_t rsp
);
	typedef enum logic [3:0] {
		A_IDLE = 4'b0001,
		A_NORM = 4'b0010,
		A_ITER = 4'b0100,
		A_DONE = 4'b1000
	} astate_t;

	astate_t st_q;
	logic signed [65:0] x_q, y_q;
	logic signed [27:0] z_q;
	logic [4:0] i_q;

	logic [65:0] ax, ay;
	logic big, tiny;
	logic signed [65:0] dx, dy;

	always_comb begin
		ax = x_q[65] ? 66'(-x_q) : 66'(x_q);
		ay = y_q[65] ? 66'(-y_q) : 66'(y_q);
		big = (ax >= (66'd1 << 40)) || (ay >= (66'd1 << 40));
		tiny = (ax < (66'd1 << 38)) && (ay < (66'd1 << 38));
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= A_IDLE;
			i_q <= '0;
		end else begin
			unique case (st_q)
				A_IDLE: if (req.start) begin
					i_q <= '0;
					if (req.y == 0 || req.x == 0) st_q <= A_DONE;
					else st_q <= A_NORM;
				end
				A_NORM: if (!big && !tiny) st_q <= A_ITER;
				A_ITER: begin
					i_q <= i_q + 5'd1;
					if (i_q == 5'(CordicSteps - 1)) st_q <= A_DONE;
				end
				A_DONE: st_q <= A_IDLE;
				default: st_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			A_IDLE: if (req.start) begin
				x_q <= 66'(req.x);
				y_q <= 66'(req.y);
				if (req.y == 0) z_q <= '0;
				else if (req.x == 0) z_q <= req.y[63] ? -HalfPiQ24 : HalfPiQ24;
				else z_q <= '0;
			end
			A_NORM: begin
				if (big) begin
					x_q <= x_q >>> 1;
					y_q <= y_q >>> 1;
				end else if (tiny) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end
			end
			A_ITER: begin
				if (y_q > 0) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_entry(i_q);
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_entry(i_q);
				end
			end
			default: ;
		endcase
	end

	assign rsp.done = (st_q == A_DONE);
	assign rsp.z = z_q;

	state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q)) else $error("cordic state not one-hot");
	done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done) else $error("cordic done held");
endmodule

// ===== sv/stanley_steer_pi_speed_control.sv =====
// Top level: Stanley steering law and PI speed loop sequencer.
// Usage:
//   in_valid/in_ready carry one in_item_t. A path item (operation 1) updates the
//   stored steer angle and produces nothing. A speed item (operation 0) updates
//   the speed integrator and produces one out_item_t on out_valid/out_ready.
//   cfg_valid/cfg_ready write one of eight 23-bit registers; writes are taken
//   at any time but must only be issued while the block is idle.
// Resources:
//   All products go through one bit-serial multiplier and angles through one
//   CORDIC unit (normalization shifts then 24 steps; a zero operand skips both).
//   A speed item's result shows on out_valid in the same cycle as in_ready
//   returns. One item is in flight at a time.
// Reset: registers take their defaults, integrator, speed and steer angle
//   clear, and the block is ready for an item once reset is released.
// Stall: a result waits in the output register; the next item is accepted
//   while it waits, and its result is held back until the register is free.
module stanley_steer_pi_speed_control import sspc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  cfg_item_t cfg_data
);
	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_P_NUM = 16'h0002,
		S_P_AT1 = 16'h0004,
		S_P_FFM = 16'h0008,
		S_P_AT2 = 16'h0010,
		S_P_YAW = 16'h0020,
		S_P_CRV = 16'h0040,
		S_P_SUM = 16'h0080,
		S_V_DT  = 16'h0100,
		S_V_PG  = 16'h0200,
		S_V_IG  = 16'h0400,
		S_V_ST  = 16'h0800,
		S_V_OUT = 16'h1000,
		S_WAIT  = 16'h2000
	} state_t;

	state_t st_q;
	logic issued_q;
	logic [CfgW-1:0] target_speed_q, prop_gain_q, int_gain_q, integral_limit_q;
	logic [CfgW-1:0] stanley_gain_q, wheelbase_q, yaw_gain_q, curv_gain_q;
	logic signed [31:0] speed_integral_q, stored_speed_q, steer_angle_q;
	in_item_t item_q;
	logic signed [63:0] t1_q, t2_q, t3_q;
	out_item_t res_q;
	logic out_valid_q;

	mul_req_t mreq;
	mul_rsp_t mrsp;
	atan_req_t areq;
	atan_rsp_t arsp;

	sspc_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));
	sspc_atan u_atan (.clk(clk), .arst_n(arst_n), .req(areq), .rsp(arsp));

	logic signed [63:0] prod_q16;
	logic signed [63:0] prod_q24;
	logic signed [63:0] ang_q;
	logic signed [63:0] den;
	logic signed [63:0] err;
	logic signed [63:0] integ, lim, u, sum;
	logic signed [63:0] st_val;
	logic unit_done;
	assign prod_q16 = 64'(mrsp.p >>> FracBits);
	assign prod_q24 = 64'(mrsp.p >>> AngBits);
	assign ang_q = 64'(arsp.z >>> (AngBits - FracBits));
	assign err = 64'(signed'({1'b0, target_speed_q})) - 64'(item_q.speed);
	assign den = (64'(stored_speed_q) + 64'sd65536) <<< FracBits;
	assign lim = 64'(signed'({1'b0, integral_limit_q}));
	assign unit_done = mrsp.done | arsp.done;

	always_comb begin
		mreq = '0;
		areq = '0;
		if (!issued_q) begin
			unique case (st_q)
				S_P_NUM: begin
					mreq.start = 1'b1;
					mreq.a = 64'(item_q.cross_track_error);
					mreq.b = 32'(stanley_gain_q);
				end
				S_P_AT1: begin
					areq.start = 1'b1;
					areq.y = den[63] ? -t1_q : t1_q;
					areq.x = den[63] ? -den : den;
				end
				S_P_FFM: begin
					mreq.start = 1'b1;
					mreq.a = 64'(item_q.path_curvature);
					mreq.b = 32'(wheelbase_q);
				end
				S_P_AT2: begin
					areq.start = 1'b1;
					areq.y = t2_q;
					areq.x = 64'sd1 <<< (2 * FracBits);
				end
				S_P_YAW: begin
					mreq.start = 1'b1;
					mreq.a = 64'(item_q.heading_error);
					mreq.b = 32'(yaw_gain_q);
				end
				S_P_CRV: begin
					mreq.start = 1'b1;
					mreq.a = t2_q;
					mreq.b = 32'(curv_gain_q);
				end
				S_V_DT: begin
					mreq.start = 1'b1;
					mreq.a = err;
					mreq.b = 32'(DtQ24);
				end
				S_V_PG: begin
					mreq.start = 1'b1;
					mreq.a = err;
					mreq.b = 32'(prop_gain_q);
				end
				S_V_IG: begin
					mreq.start = 1'b1;
					mreq.a = 64'(speed_integral_q);
					mreq.b = 32'(int_gain_q);
				end
				S_V_ST: begin
					mreq.start = 1'b1;
					mreq.a = 64'(steer_angle_q);
					mreq.b = 32'(SteerScaleQ24);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		integ = 64'(speed_integral_q) + prod_q24;
		if (integ > lim) integ = lim;
		else if (integ < -lim) integ = -lim;
		u = t1_q + prod_q16;
		sum = t3_q + t1_q - t2_q;
		st_val = prod_q24;
		if (st_val > 64'sd65536) st_val = 64'sd65536;
		else if (st_val < -64'sd65536) st_val = -64'sd65536;
	end

	assign in_ready = (st_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			issued_q <= 1'b0;
			out_valid_q <= 1'b0;
			target_speed_q <= 23'd1456210;
			prop_gain_q <= 23'd65536;
			int_gain_q <= 23'd4588;
			integral_limit_q <= 23'd327680;
			stanley_gain_q <= 23'd183501;
			wheelbase_q <= 23'd186778;
			yaw_gain_q <= 23'd131072;
			curv_gain_q <= 23'd262144;
			speed_integral_q <= '0;
			stored_speed_q <= '0;
			steer_angle_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_data.index)
					RegTargetSpeed: target_speed_q <= cfg_data.data[CfgW-1:0];
					RegPropGain: prop_gain_q <= cfg_data.data[CfgW-1:0];
					RegIntGain: int_gain_q <= cfg_data.data[CfgW-1:0];
					RegIntegralLimit: integral_limit_q <= cfg_data.data[CfgW-1:0];
					RegStanleyGain: stanley_gain_q <= cfg_data.data[CfgW-1:0];
					RegWheelbase: wheelbase_q <= cfg_data.data[CfgW-1:0];
					RegYawGain: yaw_gain_q <= cfg_data.data[CfgW-1:0];
					RegCurvGain: curv_gain_q <= cfg_data.data[CfgW-1:0];
					default: ;
				endcase
			end
			if (st_q == S_WAIT && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (unit_done) issued_q <= 1'b0;
			else if (mreq.start || areq.start) issued_q <= 1'b1;
			unique case (st_q)
				S_IDLE: if (in_valid) begin
					st_q <= (in_data.operation == OpPath) ? S_P_NUM : S_V_DT;
				end
				S_P_NUM: if (mrsp.done) st_q <= S_P_AT1;
				S_P_AT1: if (arsp.done) st_q <= S_P_FFM;
				S_P_FFM: if (mrsp.done) st_q <= S_P_AT2;
				S_P_AT2: if (arsp.done) st_q <= S_P_YAW;
				S_P_YAW: if (mrsp.done) st_q <= S_P_CRV;
				S_P_CRV: if (mrsp.done) st_q <= S_P_SUM;
				S_P_SUM: begin
					if (sum > 64'sd2147483647) steer_angle_q <= 32'sh7fffffff;
					else if (sum < -64'sd2147483648) steer_angle_q <= 32'sh80000000;
					else steer_angle_q <= 32'(sum);
					st_q <= S_IDLE;
				end
				S_V_DT: if (mrsp.done) begin
					stored_speed_q <= item_q.speed;
					speed_integral_q <= 32'(integ);
					st_q <= S_V_PG;
				end
				S_V_PG: if (mrsp.done) st_q <= S_V_IG;
				S_V_IG: if (mrsp.done) st_q <= S_V_ST;
				S_V_ST: if (mrsp.done) st_q <= S_V_OUT;
				S_V_OUT: st_q <= S_WAIT;
				S_WAIT: if (!out_valid_q || out_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && in_valid) item_q <= in_data;
		unique case (st_q)
			S_P_NUM: if (mrsp.done) t1_q <= 64'(mrsp.p);
			S_P_AT1: if (arsp.done) t1_q <= ang_q;
			S_P_FFM: if (mrsp.done) t2_q <= 64'(mrsp.p);
			S_P_AT2: if (arsp.done) t2_q <= ang_q;
			S_P_YAW: if (mrsp.done) t3_q <= prod_q16;
			S_P_CRV: if (mrsp.done) t2_q <= prod_q16;
			S_V_PG: if (mrsp.done) t1_q <= prod_q16;
			S_V_IG: if (mrsp.done) t1_q <= u;
			S_V_ST: if (mrsp.done) t2_q <= st_val;
			S_WAIT: if (!out_valid_q || out_ready) begin
				res_q.throttle <= (t1_q > 0) ?
					((t1_q > 64'sd65536) ? 17'd65536 : 17'(t1_q)) : 17'd0;
				res_q.brake <= (t1_q < 0) ?
					((t1_q < -64'sd65536) ? 17'd65536 : 17'(-t1_q)) : 17'd0;
				res_q.steer <= 18'(t2_q);
			end
			default: ;
		endcase
	end

	state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q)) else $error("sequencer state not one-hot");
	no_double_start: assert property (@(posedge clk) disable iff (!arst_n)
		!(mreq.start && areq.start)) else $error("two units started at once");
	out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped while stalled");
endmodule
